// ===== src/amc_pkg.sv =====
// Shared types and constants for the alarm match and chime controller.
// No dependencies; every other file in src imports this package.
package amc_pkg;

  localparam int ALARM_SLOTS = 4;
  localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  localparam int OP_W     = 2;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int DAY_W    = 5;
  localparam int ALARM_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int ENABLE_W  = 4;
  localparam int HOURS_W   = 20;
  localparam int MINUTES_W = 24;

  // Operation codes carried by an input item.
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_DISMISS = 2'd1;
  localparam logic [OP_W-1:0] OP_CHIME   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOURS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTES     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHIME_EN    = 2'd3;

  typedef struct packed {
    logic [ENABLE_W-1:0]  enable_mask;
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic                 chime_enable;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [HOUR_W-1:0]   current_hour;
    logic [MINUTE_W-1:0] current_minute;
    logic [DAY_W-1:0]    current_day;
    logic                night_mode;
  } item_t;

  typedef struct packed {
    logic               served_source;
    logic [ALARM_W-1:0] served_alarm;
    logic               start_pattern;
    logic               beeper_on;
    logic               any_alarm_beeping;
  } result_t;

endpackage

// ===== src/amc_if.sv =====
// Handshake channel interfaces: input items, result items and config writes.
// Depends on amc_pkg for field widths.
interface amc_item_if;
  import amc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [HOUR_W-1:0]   current_hour;
  logic [MINUTE_W-1:0] current_minute;
  logic [DAY_W-1:0]    current_day;
  logic                night_mode;
  modport source (output valid, operation, current_hour, current_minute, current_day,
                  night_mode, input ready);
  modport sink   (input valid, operation, current_hour, current_minute, current_day,
                  night_mode, output ready);
endinterface

interface amc_result_if;
  import amc_pkg::*;
  logic               valid;
  logic               ready;
  logic               served_source;
  logic [ALARM_W-1:0] served_alarm;
  logic               start_pattern;
  logic               beeper_on;
  logic               any_alarm_beeping;
  modport source (output valid, served_source, served_alarm, start_pattern, beeper_on,
                  any_alarm_beeping, input ready);
  modport sink   (input valid, served_source, served_alarm, start_pattern, beeper_on,
                  any_alarm_beeping, output ready);
endinterface

interface amc_cfg_if;
  import amc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/amc_cfg_regs.sv =====
// Configuration register file: enable mask, alarm times and chime enable.
// Depends on amc_pkg and amc_cfg_if.
module amc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  amc_cfg_if.sink       cfg,
  output amc_pkg::cfg_t regs
);
  import amc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE_MASK: regs.enable_mask  <= cfg.data[ENABLE_W-1:0];
        REG_HOURS:       regs.hours        <= cfg.data[HOURS_W-1:0];
        REG_MINUTES:     regs.minutes      <= cfg.data[MINUTES_W-1:0];
        REG_CHIME_EN:    regs.chime_enable <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/amc_engine.sv =====
// Alarm and chime state with the single-pass update and beeper service logic.
// Depends on amc_pkg.
module amc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  amc_pkg::item_t   item,
  input  amc_pkg::cfg_t    regs,
  output amc_pkg::result_t res
);
  import amc_pkg::*;

  logic [DAY_W-1:0]       alarm_last_day [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] alarm_sounding;
  logic [ALARM_SLOTS-1:0] alarm_dismissed;
  logic [ALARM_SLOTS-1:0] alarm_start;
  logic [HOUR_W-1:0]      chime_last_hour;
  logic                   chime_sounding;
  logic                   chime_start;
  logic                   chime_manual_request;

  logic [DAY_W-1:0]       alarm_last_day_next [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] alarm_sounding_next;
  logic [ALARM_SLOTS-1:0] alarm_dismissed_next;
  logic [ALARM_SLOTS-1:0] alarm_start_next;
  logic [HOUR_W-1:0]      chime_last_hour_next;
  logic                   chime_sounding_next;
  logic                   chime_start_next;
  logic                   chime_manual_request_next;

  logic [ALARM_SLOTS-1:0] slot_on;

  // Slots beyond the width of the enable mask are never enabled.
  always_comb begin
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      slot_on[i] = (i < ENABLE_W) ? regs.enable_mask[i] : 1'b0;
    end
  end

  always_comb begin
    logic              conflict;
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [HOUR_W-1:0]   s_hour;
    logic [MINUTE_W-1:0] s_min;

    alarm_last_day_next       = alarm_last_day;
    alarm_sounding_next       = alarm_sounding;
    alarm_dismissed_next      = alarm_dismissed;
    alarm_start_next          = alarm_start;
    chime_last_hour_next      = chime_last_hour;
    chime_sounding_next       = chime_sounding;
    chime_start_next          = chime_start;
    chime_manual_request_next = chime_manual_request;
    conflict = 1'b0;
    found    = 1'b0;
    idx      = '0;
    s_hour   = '0;
    s_min    = '0;

    case (item.operation)
      OP_TICK: begin
        // The hourly chime is held back when an enabled alarm owns the full hour; a pending manual request is not.
        for (int i = 0; i < ALARM_SLOTS; i++) begin
          s_hour = regs.hours[HOUR_W*i +: HOUR_W];
          s_min  = regs.minutes[MINUTE_W*i +: MINUTE_W];
          if (slot_on[i] && s_min == '0 && s_hour == item.current_hour) begin
            conflict = 1'b1;
          end
        end
        if (regs.chime_enable && !item.night_mode) begin
          if (chime_manual_request || (chime_last_hour != item.current_hour &&
              item.current_minute == '0 && !conflict)) begin
            chime_manual_request_next = 1'b0;
            chime_last_hour_next      = item.current_hour;
            chime_sounding_next       = 1'b1;
            chime_start_next          = 1'b1;
          end
        end
        for (int i = 0; i < ALARM_SLOTS; i++) begin
          s_hour = regs.hours[HOUR_W*i +: HOUR_W];
          s_min  = regs.minutes[MINUTE_W*i +: MINUTE_W];
          if (slot_on[i]) begin
            if (item.current_hour == s_hour && item.current_minute == s_min &&
                item.current_day != alarm_last_day[i]) begin
              alarm_last_day_next[i]  = item.current_day;
              alarm_sounding_next[i]  = 1'b1;
              alarm_dismissed_next[i] = 1'b0;
              alarm_start_next[i]     = 1'b1;
            end else if (item.current_minute != s_min) begin
              alarm_sounding_next[i] = 1'b0;
              alarm_start_next[i]    = 1'b0;
            end
          end
        end
      end
      OP_DISMISS: begin
        for (int i = 0; i < ALARM_SLOTS; i++) begin
          if (alarm_sounding[i]) begin
            alarm_dismissed_next[i] = 1'b1;
            alarm_sounding_next[i]  = 1'b0;
          end
        end
      end
      OP_CHIME: begin
        chime_manual_request_next = 1'b1;
      end
      default: begin
      end
    endcase

    // Dismissed slots never count, so silencing them below cannot change this.
    res.any_alarm_beeping = |(alarm_sounding_next & slot_on & ~alarm_dismissed_next);

    // Priority scan: dismissed slots ahead of the winner are forced silent.
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      if (!found) begin
        if (!alarm_dismissed_next[i] && alarm_sounding_next[i] && slot_on[i]) begin
          found = 1'b1;
          idx   = SLOT_W'(i);
        end else if (alarm_dismissed_next[i]) begin
          alarm_sounding_next[i] = 1'b0;
        end
      end
    end

    if (found) begin
      res.served_source     = 1'b1;
      res.served_alarm      = ALARM_W'(idx);
      res.start_pattern     = alarm_start_next[idx];
      res.beeper_on         = 1'b1;
      alarm_start_next[idx] = 1'b0;
      chime_sounding_next   = 1'b0;
      chime_start_next      = 1'b0;
    end else begin
      res.served_source = 1'b0;
      res.served_alarm  = '0;
      res.start_pattern = chime_start_next;
      res.beeper_on     = chime_sounding_next;
      chime_start_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        alarm_last_day[i] <= '0;
      end
      alarm_sounding       <= '0;
      alarm_dismissed      <= '0;
      alarm_start          <= '0;
      chime_last_hour      <= '0;
      chime_sounding       <= 1'b0;
      chime_start          <= 1'b0;
      chime_manual_request <= 1'b0;
    end else if (step) begin
      alarm_last_day       <= alarm_last_day_next;
      alarm_sounding       <= alarm_sounding_next;
      alarm_dismissed      <= alarm_dismissed_next;
      alarm_start          <= alarm_start_next;
      chime_last_hour      <= chime_last_hour_next;
      chime_sounding       <= chime_sounding_next;
      chime_start          <= chime_start_next;
      chime_manual_request <= chime_manual_request_next;
    end
  end

endmodule

// ===== src/alarm_match_and_chime_controller.sv =====
// Top level of the alarm match and chime controller.
// Depends on amc_pkg, the channel interfaces in amc_if, amc_cfg_regs and amc_engine.

// The controller takes one item per clock cycle while the result channel is not
// stalled and returns exactly one result item for each. An item first lands in an
// input register; from there one pass of combinational logic updates the alarm and
// chime state and forms the result, which is held in an output register until the
// consumer takes it. The input side stays ready while a finished result waits, so
// one further item can be held behind it before back-pressure reaches the item
// channel. A time tick evaluates the hourly chime first (skipped in night mode or
// when the chime is disabled, and, with no manual request pending, when an enabled
// alarm is set on that full hour), then matches every enabled alarm slot against the
// hour and minute; an alarm fires at most once per day and stops when the minute
// moves on. A dismiss item silences every sounding alarm, and a manual chime item
// leaves a request that the next chime evaluation honours. After every item the
// lowest-numbered sounding, undismissed, enabled alarm is served and silences the
// chime; failing that, the chime beeper is served. Configuration writes are accepted
// in every cycle and must only be made while no item is in flight.
module alarm_match_and_chime_controller (
  input  logic          clk,
  input  logic          rst,
  amc_item_if.sink      items,
  amc_result_if.source  results,
  amc_cfg_if.sink       cfg
);
  import amc_pkg::*;

  cfg_t    regs;
  item_t   item;
  logic    item_valid;
  result_t res;
  result_t res_q;
  logic    res_valid;
  logic    advance;

  // The held item moves on when the output register is empty or is being emptied.
  assign advance     = item_valid && (!res_valid || results.ready);
  assign items.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      item.operation      <= items.operation;
      item.current_hour   <= items.current_hour;
      item.current_minute <= items.current_minute;
      item.current_day    <= items.current_day;
      item.night_mode     <= items.night_mode;
    end
  end

  amc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // State is committed in the same cycle the result enters the output register.
  amc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item),
    .regs (regs),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign results.valid             = res_valid;
  assign results.served_source     = res_q.served_source;
  assign results.served_alarm      = res_q.served_alarm;
  assign results.start_pattern     = res_q.start_pattern;
  assign results.beeper_on         = res_q.beeper_on;
  assign results.any_alarm_beeping = res_q.any_alarm_beeping;

endmodule
